FILE: src/anbs_pkg.sv
package anbs_pkg;

	localparam int POSITION_BITS_DEF = 32;
	localparam int OUT_BITS          = 32;
	localparam int PREFIX_BITS       = 3;
	localparam int TYPE_BITS         = 6;

	localparam logic [7:0]             BYTE_ZERO    = 8'h00;
	localparam logic [7:0]             BYTE_ONE     = 8'h01;
	localparam logic [6:0]             HDR_MASK     = 7'h7F;
	localparam logic [PREFIX_BITS-1:0] SC_SHORT     = 3'd3;
	localparam logic [PREFIX_BITS-1:0] SC_LONG      = 3'd4;
	localparam logic [1:0]             ZRUN_SC      = 2'd2;
	localparam logic [1:0]             ZRUN_MAX     = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} byte_item_t;

	typedef struct packed {
		logic [OUT_BITS-1:0]    unit_start;
		logic [PREFIX_BITS-1:0] prefix_size;
		logic [OUT_BITS-1:0]    payload_offset;
		logic [OUT_BITS-1:0]    unit_length;
		logic [TYPE_BITS-1:0]   unit_type;
		logic                   final_unit;
	} rec_t;

endpackage

FILE: src/anbs_byte_if.sv
interface anbs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

FILE: src/anbs_rec_if.sv
interface anbs_rec_if;
	logic        valid;
	logic        ready;
	logic [31:0] unit_start;
	logic [2:0]  prefix_size;
	logic [31:0] payload_offset;
	logic [31:0] unit_length;
	logic [5:0]  unit_type;
	logic        final_unit;

	modport source (output valid, output unit_start, output prefix_size,
		output payload_offset, output unit_length, output unit_type,
		output final_unit, input ready);
	modport sink   (input valid, input unit_start, input prefix_size,
		input payload_offset, input unit_length, input unit_type,
		input final_unit, output ready);
endinterface

FILE: src/anbs_in_stage.sv
module anbs_in_stage
	import anbs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	anbs_byte_if.sink       bytes,
	input  logic            advance,
	output logic            item_valid,
	output byte_item_t      item
);

	logic       valid_s1;
	byte_item_t item_s1;

	// stage empties or hands on in the same cycle
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1.data_byte     <= bytes.data_byte;
			item_s1.end_of_stream <= bytes.end_of_stream;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

FILE: src/anbs_parse.sv
module anbs_parse
	import anbs_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  byte_item_t item,
	output logic       emit,
	output rec_t       rec
);

	localparam int WIDE = (POSITION_BITS > OUT_BITS) ? POSITION_BITS : OUT_BITS;

	logic [1:0]               zrun_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [PREFIX_BITS-1:0]   prefix_q;
	logic [TYPE_BITS-1:0]     type_q;
	logic                     hdr_q;
	logic                     open_q;

	logic                     is_hdr;
	logic                     is_sc;
	logic [PREFIX_BITS-1:0]   sc_prefix;
	logic [POSITION_BITS-1:0] sc_start;
	logic [POSITION_BITS-1:0] pos_next;
	logic [POSITION_BITS-1:0] rec_end;
	logic [POSITION_BITS-1:0] offs;
	logic [POSITION_BITS-1:0] len;
	logic [WIDE-1:0]          w_start;
	logic [WIDE-1:0]          w_offs;
	logic [WIDE-1:0]          w_len;
	logic [TYPE_BITS-1:0]     hdr_type;
	logic                     eos;

	assign eos       = item.end_of_stream;
	assign is_hdr    = hdr_q;
	assign is_sc     = !hdr_q && (item.data_byte == BYTE_ONE) && (zrun_q >= ZRUN_SC);
	assign sc_prefix = (zrun_q == ZRUN_MAX) ? SC_LONG : SC_SHORT;
	assign sc_start  = pos_q - POSITION_BITS'(sc_prefix - 3'd1);
	assign pos_next  = pos_q + POSITION_BITS'(1);
	assign hdr_type  = TYPE_BITS'((item.data_byte[6:0] & HDR_MASK) >> 1);

	// record end: next start code, or one past the final byte
	assign rec_end = (is_sc && !eos) ? sc_start : pos_next;
	assign offs    = start_q + POSITION_BITS'(prefix_q);
	assign len     = rec_end - start_q;
	assign w_start = WIDE'(start_q);
	assign w_offs  = WIDE'(offs);
	assign w_len   = WIDE'(len);

	always_comb begin
		priority if (is_hdr) begin
			emit = eos;
		end else if (is_sc) begin
			emit = open_q;
		end else begin
			emit = eos && open_q;
		end
	end

	always_comb begin
		rec.unit_start     = w_start[OUT_BITS-1:0];
		rec.prefix_size    = prefix_q;
		rec.payload_offset = w_offs[OUT_BITS-1:0];
		rec.unit_length    = w_len[OUT_BITS-1:0];
		rec.unit_type      = is_hdr ? hdr_type : type_q;
		rec.final_unit     = eos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zrun_q   <= '0;
			pos_q    <= '0;
			start_q  <= '0;
			prefix_q <= '0;
			type_q   <= '0;
			hdr_q    <= 1'b0;
			open_q   <= 1'b0;
		end else if (fire) begin
			if (eos) begin
				zrun_q   <= '0;
				pos_q    <= '0;
				start_q  <= '0;
				prefix_q <= '0;
				type_q   <= '0;
				hdr_q    <= 1'b0;
				open_q   <= 1'b0;
			end else begin
				pos_q <= pos_next;
				priority if (is_hdr) begin
					type_q <= hdr_type;
					hdr_q  <= 1'b0;
					open_q <= 1'b1;
					zrun_q <= '0;
				end else if (is_sc) begin
					start_q  <= sc_start;
					prefix_q <= sc_prefix;
					hdr_q    <= 1'b1;
					open_q   <= 1'b0;
					zrun_q   <= '0;
				end else if (item.data_byte == BYTE_ZERO) begin
					zrun_q <= (zrun_q == ZRUN_MAX) ? ZRUN_MAX : zrun_q + 2'd1;
				end else begin
					zrun_q <= '0;
				end
			end
		end
	end

endmodule

FILE: src/anbs_out_stage.sv
module anbs_out_stage
	import anbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  rec_t      rec,
	output logic      can_take,
	anbs_rec_if.source records
);

	logic rec_valid_q;
	rec_t rec_q;

	assign can_take = !rec_valid_q || records.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (can_take) begin
			rec_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load) begin
			rec_q <= rec;
		end
	end

	assign records.valid          = rec_valid_q;
	assign records.unit_start     = rec_q.unit_start;
	assign records.prefix_size    = rec_q.prefix_size;
	assign records.payload_offset = rec_q.payload_offset;
	assign records.unit_length    = rec_q.unit_length;
	assign records.unit_type      = rec_q.unit_type;
	assign records.final_unit     = rec_q.final_unit;

endmodule

FILE: src/annexb_nal_unit_scanner_core.sv
// Annex B NAL unit scanner. Takes an elementary stream one byte per transaction
// and returns one record per NAL unit: start position, start code size (3 or 4),
// header byte position, length including the start code and the H.265 unit type.
// A unit's record leaves on the 01 byte that completes the next start code, or on
// the byte flagged end_of_stream (then with final_unit set); after that byte all
// positions restart at zero. Bytes ahead of the first start code are dropped, and
// a start code whose 01 byte ends the stream is ignored. One byte is taken every
// clock cycle with no stall of its own: the byte goes into an input register, the
// zero-run/start-code compare and the length subtract run combinationally against
// the scanner state, and the record lands in an output register that drives
// records. Back-pressure on records stalls the byte side only while the output
// register is full and not being taken. Positions wrap at POSITION_BITS and are
// presented on 32-bit fields.
module annexb_nal_unit_scanner_core
	import anbs_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	anbs_byte_if.sink   bytes,
	anbs_rec_if.source  records
);

	// handshake between the stages
	logic       s1_valid;
	byte_item_t s1_item;
	logic       can_take;
	logic       s1_fire;

	// parser output
	logic       emit;
	rec_t       rec;

	// a held byte is processed once the record register can take its result
	assign s1_fire = s1_valid && can_take;

	anbs_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.advance    (s1_fire),
		.item_valid (s1_valid),
		.item       (s1_item)
	);

	anbs_parse #(
		.POSITION_BITS (POSITION_BITS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (s1_fire),
		.item   (s1_item),
		.emit   (emit),
		.rec    (rec)
	);

	anbs_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s1_fire && emit),
		.rec      (rec),
		.can_take (can_take),
		.records  (records)
	);

	// a record only ever carries a legal start code size
	a_prefix_legal: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid |-> (records.prefix_size == SC_SHORT ||
			records.prefix_size == SC_LONG))
		else $error("record prefix size not 3 or 4");

	// header byte sits right after the start code
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid |-> (records.payload_offset[15:0] ==
			records.unit_start[15:0] + 16'(records.prefix_size)))
		else $error("payload offset inconsistent with start and prefix");

	// a fresh record only follows a processed byte
	a_rec_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(records.valid) |-> $past(s1_fire))
		else $error("record appeared without a processed byte");

endmodule
